FILE: hdl/pdisp_pkg.sv
// ----------------------------------------------------------------------------
// pdisp_pkg
// Shared types and codes for the periodic task dispatcher.
// ----------------------------------------------------------------------------
package pdisp_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 8;
    localparam int PERIOD_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_ARRANGE  = 2'd1,
        OP_DISMISS  = 2'd2,
        OP_RESTART  = 2'd3
    } op_t;

    // Per-cycle command broadcast to every cell of the table
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_ARRANGE,
        CELL_DISMISS,
        CELL_RESTART
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t             cmd;
        logic                  append;   // arrange found no match: load at tail
        logic [PERIOD_W-1:0]   period;
    } cell_ctl_t;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [KEY_W-1:0]      task_key;
        logic [PERIOD_W-1:0]   period;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0]      fired_key;
        logic                  fired;
        logic                  answer;
        logic                  full_res;
        logic                  last;
    } out_t;

endpackage

FILE: hdl/pdisp_cell.sv
// ----------------------------------------------------------------------------
// pdisp_cell
// One table entry: key, interval and last run. Loads from its right-hand
// neighbor on rotate and on the shift-up after a removal.
// ----------------------------------------------------------------------------
module pdisp_cell #(
    parameter int IDX      = 0,
    parameter int KEY_BITS = 8,
    parameter int CNT_W    = 5
) (
    input  logic                              aclk,
    input  pdisp_pkg::cell_ctl_t              ctl,
    input  logic [KEY_BITS-1:0]               key_in,
    input  logic [CNT_W-1:0]                  count,
    input  logic [KEY_BITS-1:0]               nb_key,
    input  logic [pdisp_pkg::PERIOD_W-1:0]    nb_period,
    input  logic [pdisp_pkg::PERIOD_W-1:0]    nb_last,
    input  logic                              shift_in,
    output logic                              shift_out,
    output logic                              match,
    output logic [KEY_BITS-1:0]               key,
    output logic [pdisp_pkg::PERIOD_W-1:0]    period,
    output logic [pdisp_pkg::PERIOD_W-1:0]    last_run
);

    logic [KEY_BITS-1:0]            key_reg;
    logic [pdisp_pkg::PERIOD_W-1:0] period_reg;
    logic [pdisp_pkg::PERIOD_W-1:0] last_reg;
    logic                           live;
    logic                           at_tail;

    assign live      = CNT_W'(IDX) < count;
    assign at_tail   = CNT_W'(IDX) == count;
    assign match     = live && (key_reg == key_in);
    assign shift_out = shift_in || match;

    assign key      = key_reg;
    assign period   = period_reg;
    assign last_run = last_reg;

    always_ff @(posedge aclk) begin
        case (ctl.cmd)
            pdisp_pkg::CELL_ROTATE: begin
                key_reg    <= nb_key;
                period_reg <= nb_period;
                last_reg   <= nb_last;
            end
            pdisp_pkg::CELL_ARRANGE: begin
                if (match) begin
                    period_reg <= ctl.period;
                end else if (ctl.append && at_tail) begin
                    key_reg    <= key_in;
                    period_reg <= ctl.period;
                    last_reg   <= '0;
                end
            end
            pdisp_pkg::CELL_DISMISS: begin
                if (shift_out) begin
                    key_reg    <= nb_key;
                    period_reg <= nb_period;
                    last_reg   <= nb_last;
                end
            end
            pdisp_pkg::CELL_RESTART: begin
                last_reg <= '0;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hdl/periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_core
// Cooperative periodic scheduler: tick counter plus an ordered ring of
// task cells that rotates past one shared elapsed-time comparator.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   s_       | in  | s_valid / s_ready  | pdisp_pkg::in_t  (operation, key, period)
//   m_       | out | m_valid / m_ready  | pdisp_pkg::out_t (one per fire or answer)
//
// Arrange, dismiss and restart finish at acceptance: one result next cycle.
// A tick rotates the whole ring once, one cell per cycle past the head
// comparator unless stalled, then passes through a flush state.
// A fire is held in a pending register so the final one can carry last.
// aresetn clears the counter, entry count and control; cell contents are
// don't-care until written. The rotation stalls only when a new fire meets
// an earlier fire result still waiting on m_ready; the flush waits likewise.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_core #(
    parameter int MAX_TASKS = 16,
    parameter int KEY_BITS  = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pdisp_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pdisp_pkg::out_t   m_data
);

    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int STEP_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int KEY_EXT = (KEY_BITS > pdisp_pkg::KEY_W) ? KEY_BITS : pdisp_pkg::KEY_W;
    localparam int PW      = pdisp_pkg::PERIOD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                     state_reg;
    logic [PW-1:0]              tick_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       pend_valid_reg;
    logic [pdisp_pkg::KEY_W-1:0] pend_key_reg;
    logic                       m_valid_reg;
    pdisp_pkg::out_t            m_data_reg;
    logic                       m_valid_next;
    pdisp_pkg::out_t            m_data_next;

    logic [KEY_BITS-1:0]        c_key    [MAX_TASKS];
    logic [PW-1:0]              c_period [MAX_TASKS];
    logic [PW-1:0]              c_last   [MAX_TASKS];
    logic [MAX_TASKS-1:0]       c_match;
    logic [MAX_TASKS:0]         shift_chain;

    pdisp_pkg::cell_ctl_t       ctl;
    logic                       out_free;
    logic                       s_fire;
    logic [KEY_EXT-1:0]         key_ext;
    logic [KEY_BITS-1:0]        key_in;
    logic [KEY_EXT-1:0]         head_key_ext;
    logic                       found;
    logic                       full;
    logic                       step_live;
    logic [PW-1:0]              elapsed;
    logic                       head_fire;
    logic                       stall;
    logic                       rot;
    logic                       last_step;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign key_ext      = KEY_EXT'(s_data.task_key);
    assign key_in       = key_ext[KEY_BITS-1:0];
    assign head_key_ext = KEY_EXT'(c_key[0]);

    assign found = |c_match;
    assign full  = count_reg == CNT_W'(MAX_TASKS);

    // head comparator: wrapped elapsed ticks against the interval
    assign step_live = CNT_W'(step_reg) < count_reg;
    assign elapsed   = tick_reg - c_last[0];
    assign head_fire = (state_reg == ST_SCAN) && step_live && (elapsed >= c_period[0]);
    assign stall     = head_fire && pend_valid_reg && !out_free;
    assign rot       = (state_reg == ST_SCAN) && !stall;
    assign last_step = step_reg == STEP_W'(MAX_TASKS - 1);

    always_comb begin
        ctl.cmd    = pdisp_pkg::CELL_HOLD;
        ctl.append = !found;
        ctl.period = s_data.period;
        if (rot) begin
            ctl.cmd = pdisp_pkg::CELL_ROTATE;
        end else if (s_fire) begin
            case (pdisp_pkg::op_t'(s_data.operation))
                pdisp_pkg::OP_ARRANGE: ctl.cmd = pdisp_pkg::CELL_ARRANGE;
                pdisp_pkg::OP_DISMISS: ctl.cmd = pdisp_pkg::CELL_DISMISS;
                pdisp_pkg::OP_RESTART: ctl.cmd = pdisp_pkg::CELL_RESTART;
                default:               ctl.cmd = pdisp_pkg::CELL_HOLD;
            endcase
        end
    end

    assign shift_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            logic [KEY_BITS-1:0] nb_key;
            logic [PW-1:0]       nb_period;
            logic [PW-1:0]       nb_last;

            if (gi < MAX_TASKS - 1) begin : g_mid
                assign nb_key    = c_key[gi+1];
                assign nb_period = c_period[gi+1];
                assign nb_last   = c_last[gi+1];
            end else begin : g_tail
                // head wraps to the tail, stamped when it fired
                assign nb_key    = c_key[0];
                assign nb_period = c_period[0];
                assign nb_last   = head_fire ? tick_reg : c_last[0];
            end

            pdisp_cell #(
                .IDX      (gi),
                .KEY_BITS (KEY_BITS),
                .CNT_W    (CNT_W)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .key_in    (key_in),
                .count     (count_reg),
                .nb_key    (nb_key),
                .nb_period (nb_period),
                .nb_last   (nb_last),
                .shift_in  (shift_chain[gi]),
                .shift_out (shift_chain[gi+1]),
                .match     (c_match[gi]),
                .key       (c_key[gi]),
                .period    (c_period[gi]),
                .last_run  (c_last[gi])
            );
        end
    endgenerate

    // result register next value
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    m_data_next = '0;
                    case (pdisp_pkg::op_t'(s_data.operation))
                        pdisp_pkg::OP_TICK: begin
                        end
                        pdisp_pkg::OP_ARRANGE: begin
                            m_valid_next     = 1'b1;
                            m_data_next.last = 1'b1;
                            if (found) begin
                                m_data_next.answer = 1'b1;
                            end else if (full) begin
                                m_data_next.full_res = 1'b1;
                            end else begin
                                m_data_next.answer = count_reg == '0;
                            end
                        end
                        pdisp_pkg::OP_DISMISS: begin
                            m_valid_next       = 1'b1;
                            m_data_next.last   = 1'b1;
                            m_data_next.answer = found;
                        end
                        default: begin
                            m_valid_next     = 1'b1;
                            m_data_next.last = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rot && head_fire && pend_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{fired_key: pend_key_reg, fired: 1'b1,
                                     answer: 1'b0, full_res: 1'b0, last: 1'b0};
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_data_next = '{fired_key: pend_key_reg, fired: 1'b1,
                                        answer: 1'b0, full_res: 1'b0, last: 1'b1};
                    end else begin
                        m_data_next = '{fired_key: '0, fired: 1'b0,
                                        answer: 1'b0, full_res: 1'b0, last: 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            count_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (pdisp_pkg::op_t'(s_data.operation))
                            pdisp_pkg::OP_TICK: begin
                                tick_reg       <= tick_reg + 1'b1;
                                step_reg       <= '0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= ST_SCAN;
                            end
                            pdisp_pkg::OP_ARRANGE: begin
                                if (!found && !full) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            pdisp_pkg::OP_DISMISS: begin
                                if (found) begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            default: begin
                                tick_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (rot) begin
                        if (head_fire) begin
                            pend_valid_reg <= 1'b1;
                            pend_key_reg   <= head_key_ext[pdisp_pkg::KEY_W-1:0];
                        end
                        step_reg <= step_reg + 1'b1;
                        if (last_step) begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/pdisp_checker.sv
// ----------------------------------------------------------------------------
// pdisp_checker
// Port-level checks on the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module pdisp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pdisp_pkg::in_t    s_data,
    input logic              m_valid,
    input logic              m_ready,
    input pdisp_pkg::out_t   m_data
);

    // a held result stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transaction");

    // table edits and restart answer in the very next cycle, as a final result
    a_edit_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.operation != pdisp_pkg::OP_TICK)
        |=> m_valid && m_data.last && !m_data.fired)
        else $error("edit result missing or malformed");

    // only fire reports may be followed by more results of the same item
    a_nonlast_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.fired)
        else $error("non-final result is not a fire report");

    a_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.fired |-> m_data.fired_key == '0)
        else $error("key set on non-fire result");

    a_full_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.full_res |-> !m_data.answer && !m_data.fired)
        else $error("full result carries answer or fire");

endmodule

bind periodic_task_dispatcher_core pdisp_checker u_pdisp_checker (.*);
